/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the pulse pattern block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/ppg_pkg.sv */
// Shared types and constants of the pulse pattern generator.
// Used by the core, the port checker and the testbench.
`default_nettype none

package ppg_pkg;

   localparam int MAX_ENTRIES    = 256;
   localparam int PERIOD_BITS    = 16;
   localparam int IDX_BITS       = $clog2(MAX_ENTRIES);
   localparam int LEN_BITS       = $clog2(MAX_ENTRIES + 1);
   localparam int ACTION_BITS    = 3;
   localparam int SLOT_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_LEVEL    = CSR_INDEX_BITS'(1);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_TICK  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_ARM   = 3'd4
   } action_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [SLOT_BITS-1:0]   entry_index;
      logic [PERIOD_BITS-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic                level;
      logic                running;
      logic                toggled;
      logic [IDX_BITS-1:0] position;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/pulse_pattern_generator_core.sv */
// Top level of the pulse pattern generator: control state, table, result register.
// Depends on ppg_pkg and ppg_ram.
//
//   channel  | direction | handshake          | payload
//   req_     | in        | req_valid/stall    | req_type: action, entry_index, entry_value
//   rsp_     | out       | rsp_valid/stall    | rsp_type: level, running, toggled, position
//   csr_     | in        | csr_valid/ready    | csr_index, csr_wdata
//
// One item is taken every cycle; its result appears in the result register on
// the next cycle. The table RAM is read continuously at the next index, so an
// expiry never waits for the memory port. Reset is synchronous and needs no
// clearing pass; the table is undefined until written. The input stalls only
// while a held result is stalled. Configuration writes are taken every cycle.
`default_nettype none

module pulse_pattern_generator_core
   import ppg_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_ENTRIES);
   localparam logic [PERIOD_BITS-1:0] ONE_PERIOD = PERIOD_BITS'(1);

   logic [LEN_BITS-1:0]    pattern_length_ff, pattern_length_in;
   logic                   start_level_ff, start_level_in;
   logic [PERIOD_BITS-1:0] remaining_ff, remaining_in;
   logic [IDX_BITS-1:0]    index_ff, index_in;
   logic                   level_ff, level_in;
   logic                   active_ff, active_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [PERIOD_BITS-1:0] fwd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   table_we;
   logic [PERIOD_BITS-1:0] table_rd_data;
   logic [PERIOD_BITS-1:0] head_period;
   logic [LEN_BITS-1:0]    index_plus;
   logic [IDX_BITS-1:0]    index_wrapped;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Configuration registers; the length saturates at the table size.
   always_comb begin
      pattern_length_in = pattern_length_ff;
      start_level_in    = start_level_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PATTERN_LENGTH) begin
            pattern_length_in = (LEN_BITS'(csr_wdata) > MAX_LEN) ? MAX_LEN
                                                                 : LEN_BITS'(csr_wdata);
         end else if (csr_index == CSR_START_LEVEL) begin
            start_level_in = csr_wdata[0];
         end
      end
   end

   // The period at index_ff: the RAM word read last cycle, unless a write
   // to that same slot landed in the cycle of the read.
   assign head_period   = fwd_valid_ff ? fwd_data_ff : table_rd_data;
   assign index_plus    = LEN_BITS'(index_ff) + LEN_BITS'(1);
   assign index_wrapped = (index_plus >= pattern_length_ff) ? '0 : IDX_BITS'(index_plus);

   assign table_we = accept && (req_data.action == ACT_WRITE) &&
                     ({1'b0, req_data.entry_index} < (SLOT_BITS + 1)'(MAX_ENTRIES));

   always_comb begin
      remaining_in = remaining_ff;
      index_in     = index_ff;
      level_in     = level_ff;
      active_in    = active_ff;
      if (accept) begin
         unique case (req_data.action)
            ACT_TICK: begin
               if (active_ff) begin
                  if (remaining_ff > ONE_PERIOD) begin
                     remaining_in = remaining_ff - ONE_PERIOD;
                  end else begin
                     level_in     = !level_ff;
                     remaining_in = (head_period == '0) ? ONE_PERIOD : head_period;
                     index_in     = index_wrapped;
                  end
               end
            end
            ACT_START: begin
               if (pattern_length_ff != '0 && !active_ff) begin
                  remaining_in = ONE_PERIOD;
                  active_in    = 1'b1;
               end
            end
            ACT_STOP: begin
               active_in = 1'b0;
               level_in  = 1'b0;
            end
            ACT_ARM: begin
               active_in    = 1'b0;
               remaining_in = '0;
               index_in     = '0;
               level_in     = start_level_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign fwd_valid_in = table_we && (IDX_BITS'(req_data.entry_index) == index_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.level    = level_in;
         rsp_data_in.running  = active_in;
         rsp_data_in.toggled  = level_in != level_ff;
         rsp_data_in.position = index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         start_level_ff    <= 1'b0;
         remaining_ff      <= '0;
         index_ff          <= '0;
         level_ff          <= 1'b0;
         active_ff         <= 1'b0;
         fwd_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_length_ff <= pattern_length_in;
         start_level_ff    <= start_level_in;
         remaining_ff      <= remaining_in;
         index_ff          <= index_in;
         level_ff          <= level_in;
         active_ff         <= active_in;
         fwd_valid_ff      <= fwd_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= req_data.entry_value;
      rsp_data_ff <= rsp_data_in;
   end

   ppg_ram #(
      .WIDTH (PERIOD_BITS),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (IDX_BITS'(req_data.entry_index)),
      .wr_data (req_data.entry_value),
      .rd_addr (index_in),
      .rd_data (table_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/ppg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Holds the period table of the pulse pattern generator; no dependencies.
`default_nettype none

module ppg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/ppg_checker.sv */
// Port-level checker for the pulse pattern generator core, bound to the top level.
// Depends on ppg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ppg_checker
   import ppg_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire req_type                   req_data,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire rsp_type                   rsp_data,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index
);

   logic req_take;
   logic cfg_take;

   assign req_take = req_valid && !req_stall;
   assign cfg_take = csr_valid && csr_ready && (csr_index == CSR_PATTERN_LENGTH);

   // A held result stays in place until it is taken.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Every accepted word produces a result on the following cycle.
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, req_take, rsp_valid)

   // Stop forces the output low and halts the pattern.
   `ASSERT_NEXT(a_stop_low, clock, reset, req_take && (req_data.action == ACT_STOP),
                !rsp_data.level && !rsp_data.running)

   // Arm rewinds the table position and leaves the block stopped.
   `ASSERT_NEXT(a_arm_rewind, clock, reset, req_take && (req_data.action == ACT_ARM),
                (rsp_data.position == '0) && !rsp_data.running)

   // A length write has no effect on the result channel by itself.
   `ASSERT_SAME(a_cfg_quiet, clock, reset, cfg_take && !req_take && !rsp_valid,
                !req_stall)

endmodule

bind pulse_pattern_generator_core ppg_checker u_ppg_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for pulse_pattern_generator_core.
// Needs ppg_pkg; a predictor inside the bench tracks the table, countdown, position and pin
// level, and every result word is compared with it.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppg_pkg::*;

   localparam int RANDOM_ITEMS = 200;

   localparam logic [ACTION_BITS-1:0] ACT_SPARE_5 = ACTION_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = CSR_INDEX_BITS'(3);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   pulse_pattern_generator_core u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted block state.
   logic [PERIOD_BITS-1:0] period_copy [MAX_ENTRIES];
   bit                     slot_loaded [MAX_ENTRIES];
   logic [PERIOD_BITS-1:0] ticks_left = '0;
   int                     next_pos = 0;
   logic                   pin_level = 1'b0;
   logic                   pattern_on = 1'b0;
   logic [8:0]             len_reg = '0;
   logic                   start_level_reg = 1'b0;

   rsp_type     expected_pin_q [$];
   int          mismatches = 0;
   bit          quiet = 1'b0;
   bit          short_fill = 1'b0;
   bit          hold_valid = 1'b0;
   int unsigned gap_pending = 0;
   int unsigned hold_cycles = 0;

   function automatic int eff_length();
      return (int'(len_reg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(len_reg);
   endfunction

   function automatic int unsigned draw_gap();
      if (quiet) return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
   endfunction

   function automatic logic [PERIOD_BITS-1:0] draw_period();
      int unsigned r = $urandom_range(0, 99);
      if (short_fill) return PERIOD_BITS'($urandom_range(0, 1));
      if (r < 70) return PERIOD_BITS'($urandom_range(0, 3));
      if (r < 96) return PERIOD_BITS'($urandom_range(4, 24));
      if (r < 99) return PERIOD_BITS'($urandom);
      return '1;
   endfunction

   function automatic rsp_type step_pattern(input req_type w);
      rsp_type                r;
      logic                   prior;
      logic [PERIOD_BITS-1:0] p;
      prior = pin_level;
      case (w.action)
         ACT_TICK: begin
            if (pattern_on) begin
               if (ticks_left > 1) begin
                  ticks_left = ticks_left - 1'b1;
               end else begin
                  pin_level = ~pin_level;
                  p = period_copy[next_pos];
                  ticks_left = (p == '0) ? PERIOD_BITS'(1) : p;
                  next_pos = next_pos + 1;
                  if (next_pos >= eff_length()) next_pos = 0;
               end
            end
         end
         ACT_START: begin
            if (eff_length() != 0 && !pattern_on) begin
               ticks_left = PERIOD_BITS'(1);
               pattern_on = 1'b1;
            end
         end
         ACT_STOP: begin
            pattern_on = 1'b0;
            pin_level = 1'b0;
         end
         ACT_WRITE: begin
            period_copy[w.entry_index] = w.entry_value;
            slot_loaded[w.entry_index] = 1'b1;
         end
         ACT_ARM: begin
            pattern_on = 1'b0;
            ticks_left = '0;
            next_pos = 0;
            pin_level = start_level_reg;
         end
         default: ;
      endcase
      r.level = pin_level;
      r.running = pattern_on;
      r.toggled = (pin_level != prior);
      r.position = IDX_BITS'(next_pos);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Result side: check each accepted word, then draw the stall for the next one.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pin_q.size() == 0) begin
               $display("%0t ns: result word with nothing expected, got %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_pin_q.pop_front();
               check_field("level", want.level, rsp_data.level);
               check_field("running", want.running, rsp_data.running);
               check_field("toggled", want.toggled, rsp_data.toggled);
               check_field("position", want.position, rsp_data.position);
            end
            hold_cycles = draw_gap();
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Valid stays high across back-to-back words, so it is only lowered when the
   // next word is not sent at once.
   task automatic send_item(input logic [ACTION_BITS-1:0] act, input logic [SLOT_BITS-1:0] slot,
                            input logic [PERIOD_BITS-1:0] value);
      req_type w;
      w.action = act;
      w.entry_index = slot;
      w.entry_value = value;
      if (!hold_valid) begin
         repeat (gap_pending) @(posedge clock);
         req_valid <= 1'b1;
      end
      req_data <= w;
      do @(posedge clock); while (req_stall);
      expected_pin_q.push_back(step_pattern(w));
      gap_pending = draw_gap();
      hold_valid = (gap_pending == 0);
      if (!hold_valid) req_valid <= 1'b0;
   endtask

   task automatic release_req();
      if (hold_valid) req_valid <= 1'b0;
      hold_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_pin_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // A tick that would load a slot never written gets that slot written first.
   task automatic send_tick();
      if (pattern_on && ticks_left <= 1 && !slot_loaded[next_pos])
         send_item(ACT_WRITE, SLOT_BITS'(next_pos), draw_period());
      send_item(ACT_TICK, SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      release_req();
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PATTERN_LENGTH: len_reg = val;
         CSR_START_LEVEL: start_level_reg = val[0];
         default: ;
      endcase
   endtask

   // Stopped block with zero length: nothing but table writes may change state.
   task automatic test_idle_behavior();
      write_reg(CSR_SPARE_2, '1);
      write_reg(CSR_SPARE_3, '1);
      send_tick();
      send_item(ACT_START, '1, '1);
      send_item(ACT_STOP, '0, '0);
      send_item(ACT_SPARE_5, '1, '1);
      send_item(ACT_SPARE_5 + ACTION_BITS'(1), '0, '1);
      send_item(ACT_SPARE_5 + ACTION_BITS'(2), '1, '0);
      send_item(ACT_WRITE, '1, '1);
      send_item(ACT_WRITE, '0, '0);
   endtask

   // Three-slot pattern, restart, stop and arm while running.
   task automatic test_pattern_basics();
      write_reg(CSR_PATTERN_LENGTH, CSR_DATA_BITS'(3));
      write_reg(CSR_START_LEVEL, CSR_DATA_BITS'(1));
      send_item(ACT_WRITE, SLOT_BITS'(1), PERIOD_BITS'(2));
      send_item(ACT_WRITE, SLOT_BITS'(2), PERIOD_BITS'(1));
      send_item(ACT_ARM, '0, '0);
      send_item(ACT_START, '0, '0);
      repeat (6) send_tick();
      send_item(ACT_START, '1, '1);
      send_item(ACT_STOP, '1, '1);
      send_item(ACT_START, '0, '0);
      repeat (2) send_tick();
      send_item(ACT_ARM, '1, '1);
   endtask

   // Length above the table size saturates, so the position wraps after slot 255.
   task automatic test_full_table_wrap();
      short_fill = 1'b1;
      write_reg(CSR_PATTERN_LENGTH, '1);
      write_reg(CSR_START_LEVEL, '0);
      send_item(ACT_ARM, '0, '0);
      send_item(ACT_START, '0, '0);
      send_tick();
      while (next_pos != 0) send_tick();
      send_item(ACT_STOP, '0, '0);
      short_fill = 1'b0;
   endtask

   // Phases of random settings; the length often changes while a pattern runs.
   task automatic test_random_patterns();
      int                   items_sent;
      int                   phase;
      int unsigned          r;
      logic [CSR_DATA_BITS-1:0] len;
      logic [SLOT_BITS-1:0] slot;
      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         case (phase)
            0: len = '1;
            1: len = '0;
            2: len = CSR_DATA_BITS'(MAX_ENTRIES);
            default: begin
               case ($urandom_range(0, 5))
                  0: len = CSR_DATA_BITS'($urandom_range(1, 2));
                  1, 2: len = CSR_DATA_BITS'($urandom_range(3, 8));
                  3: len = CSR_DATA_BITS'($urandom_range(9, 40));
                  4: len = CSR_DATA_BITS'($urandom);
                  default: len = '0;
               endcase
            end
         endcase
         write_reg(CSR_PATTERN_LENGTH, len);
         write_reg(CSR_START_LEVEL, CSR_DATA_BITS'($urandom));
         if ($urandom_range(0, 3) != 0) begin
            send_item(ACT_ARM, SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
            send_item(ACT_START, SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
            items_sent += 2;
         end
         repeat ($urandom_range(30, 120)) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
               send_tick();
            end else if (r < 80) begin
               if ($urandom_range(0, 1) == 0 || eff_length() == 0)
                  slot = SLOT_BITS'($urandom);
               else
                  slot = SLOT_BITS'($urandom_range(0, eff_length() - 1));
               send_item(ACT_WRITE, slot, draw_period());
            end else if (r < 84) begin
               send_item(ACT_START, SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
            end else if (r < 87) begin
               send_item(ACT_STOP, SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
            end else if (r < 91) begin
               send_item(ACT_ARM, SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
            end else begin
               send_item(ACT_SPARE_5 + ACTION_BITS'($urandom_range(0, 2)),
                         SLOT_BITS'($urandom), PERIOD_BITS'($urandom));
            end
            items_sent++;
         end
         phase++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_idle_behavior();
      test_pattern_basics();
      test_full_table_wrap();
      test_random_patterns();
      release_req();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
